// ----- design/crbt_pkg.sv -----
// shared constants, codes and types of the csma retry backoff table
package crbt_pkg;

  localparam int NUM_NEIGHBORS = 16;
  localparam int NUM_ENTRIES   = NUM_NEIGHBORS + 1;
  localparam int ENTRY_W       = $clog2(NUM_ENTRIES);

  localparam int TIME_W       = 32;
  localparam int CNT_W        = 8;
  localparam int ENTRY_DATA_W = TIME_W + 2 * CNT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // command modes
  localparam logic [1:0] MODE_REPORT   = 2'd0;
  localparam logic [1:0] MODE_POSTPONE = 2'd1;
  localparam logic [1:0] MODE_CHECK    = 2'd2;

  // transmit outcomes and final status codes
  localparam logic [2:0] OUT_OK        = 3'd0;
  localparam logic [2:0] OUT_ERR       = 3'd1;
  localparam logic [2:0] OUT_COLLISION = 3'd2;
  localparam logic [2:0] OUT_NOACK     = 3'd3;
  localparam logic [2:0] OUT_FATAL     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CSMA       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MAX_TX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_PERIOD   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] next;
    logic [CNT_W-1:0]  tx;
    logic [CNT_W-1:0]  col;
  } entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ----- design/crbt_ram.sv -----
// generic single-port-write ram with registered read
module crbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/crbt_ctrl.sv -----
// controller state machine: accept, calculate, write back
module crbt_ctrl
  import crbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_CALC;
      ST_CALC:   state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.calc   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CALC:   cmd.calc = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

endmodule

// ----- design/crbt_datapath.sv -----
// datapath: config registers, entry ram, retry and backoff arithmetic, result registers
module crbt_datapath
  import crbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            mode,
  input  logic [4:0]            dest_index,
  input  logic [2:0]            outcome,
  input  logic [TIME_W-1:0]     now,
  input  logic [7:0]            random_value,
  input  logic [7:0]            frame_max_transmissions,
  input  logic [TIME_W-1:0]     postpone_ticks,
  output logic                  done,
  output logic                  eligible,
  output logic                  frame_done,
  output logic [2:0]            final_status,
  output logic [CNT_W-1:0]      tx_count,
  output logic [TIME_W-1:0]     retry_time
);

  // configuration
  logic [3:0]       min_be;
  logic [3:0]       max_be;
  logic [CNT_W-1:0] max_csma;
  logic [CNT_W-1:0] default_max_tx;
  logic [15:0]      retry_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_be         <= 4'd3;
      max_be         <= 4'd5;
      max_csma       <= 8'd4;
      default_max_tx <= 8'd4;
      retry_period   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_BE:         min_be <= cfg_data[3:0];
        REG_MAX_BE:         max_be <= cfg_data[3:0];
        REG_MAX_CSMA:       max_csma <= cfg_data[7:0];
        REG_DEFAULT_MAX_TX: default_max_tx <= cfg_data[7:0];
        REG_RETRY_PERIOD:   retry_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // command capture
  logic [1:0]         mode_q;
  logic [ENTRY_W-1:0] addr_q;
  logic [2:0]         outcome_q;
  logic [TIME_W-1:0]  now_q;
  logic [7:0]         rnd_q;
  logic [7:0]         fmax_q;
  logic [TIME_W-1:0]  ticks_q;
  logic               item_ok;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q    <= mode;
      addr_q    <= ENTRY_W'(dest_index);
      outcome_q <= outcome;
      now_q     <= now;
      rnd_q     <= random_value;
      fmax_q    <= frame_max_transmissions;
      ticks_q   <= postpone_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_ok <= 1'b0;
    end else if (cmd.load) begin
      item_ok <= (int'(dest_index) <= NUM_NEIGHBORS) && (mode <= MODE_CHECK);
    end
  end

  // entry storage: active flags in flops, the rest in ram
  logic [NUM_ENTRIES-1:0] active;
  entry_t                 rd_entry;
  entry_t                 wr_entry;
  logic [TIME_W-1:0]      next_final;

  crbt_ram #(
    .WIDTH(ENTRY_DATA_W),
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.finish && item_ok),
    .waddr(addr_q),
    .wdata(wr_entry),
    .re   (cmd.load),
    .raddr(ENTRY_W'(dest_index)),
    .rdata(rd_entry)
  );

  // calculate stage
  entry_t           base;
  logic [CNT_W-1:0] tx_inc;
  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] bo_tx;
  logic [CNT_W-1:0] bo_col;
  logic [9:0]       be_sum;
  logic [9:0]       be_dec;
  logic [3:0]       be;
  logic [15:0]      be_mask;
  logic [7:0]       periods;
  logic [23:0]      product;
  logic [TIME_W-1:0] diff;

  logic [CNT_W-1:0]  tx_c,     tx_q;
  logic [CNT_W-1:0]  col_c,    col_q;
  logic              done_c,   done_q;
  logic [2:0]        status_c, status_q;
  logic              elig_c,   elig_q;
  logic              add_c,    add_q;
  logic [TIME_W-1:0] addend_c, addend_q;
  logic [TIME_W-1:0] base_next_q;

  always_comb begin
    // an inactive entry starts fresh at now with zero counts
    if (active[addr_q]) begin
      base = rd_entry;
    end else begin
      base.next = now_q;
      base.tx   = '0;
      base.col  = '0;
    end
    tx_inc  = sat_inc(base.tx);
    col_inc = sat_inc(base.col);
    limit   = (fmax_q != '0) ? fmax_q : default_max_tx;

    if (outcome_q == OUT_COLLISION) begin
      bo_tx  = base.tx;
      bo_col = col_inc;
    end else begin
      bo_tx  = tx_inc;
      bo_col = base.col;
    end
    be_sum  = 10'(bo_col) + 10'(bo_tx) + 10'(min_be);
    be_dec  = (be_sum == '0) ? '0 : be_sum - 10'd1;
    be      = (be_dec > 10'(max_be)) ? max_be : be_dec[3:0];
    be_mask = (16'd1 << be) - 16'd1;
    periods = rnd_q & be_mask[7:0];
    product = retry_period * periods;

    // wrap-safe compare: sign of now - next
    diff = now_q - base.next;

    tx_c     = base.tx;
    col_c    = base.col;
    done_c   = 1'b0;
    status_c = OUT_OK;
    elig_c   = 1'b0;
    add_c    = 1'b0;
    addend_c = '0;
    unique case (mode_q)
      MODE_CHECK: elig_c = ~diff[TIME_W-1];
      MODE_POSTPONE: begin
        add_c    = 1'b1;
        addend_c = ticks_q;
      end
      MODE_REPORT: begin
        unique case (outcome_q)
          OUT_OK: begin
            tx_c     = tx_inc;
            done_c   = 1'b1;
            status_c = OUT_OK;
          end
          OUT_ERR: begin
            add_c    = 1'b1;
            addend_c = TIME_W'(retry_period);
          end
          OUT_COLLISION: begin
            col_c = col_inc;
            if (col_inc <= max_csma) begin
              add_c    = 1'b1;
              addend_c = TIME_W'(product);
            end else begin
              done_c   = 1'b1;
              status_c = OUT_COLLISION;
            end
          end
          OUT_NOACK: begin
            tx_c = tx_inc;
            if (tx_inc < limit) begin
              add_c    = 1'b1;
              addend_c = TIME_W'(product);
            end else begin
              done_c   = 1'b1;
              status_c = OUT_NOACK;
            end
          end
          default: begin
            // fatal and unknown outcomes finish as fatal
            done_c   = 1'b1;
            status_c = OUT_FATAL;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      tx_q        <= tx_c;
      col_q       <= col_c;
      done_q      <= done_c;
      status_q    <= status_c;
      elig_q      <= elig_c;
      add_q       <= add_c;
      addend_q    <= addend_c;
      base_next_q <= base.next;
    end
  end

  // write-back stage
  always_comb begin
    next_final    = add_q ? now_q + addend_q : base_next_q;
    wr_entry.next = next_final;
    wr_entry.tx   = tx_q;
    wr_entry.col  = col_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.finish && item_ok) begin
      active[addr_q] <= ~done_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (item_ok) begin
        eligible     <= elig_q;
        frame_done   <= done_q;
        final_status <= done_q ? status_q : OUT_OK;
        tx_count     <= tx_q;
        retry_time   <= next_final;
      end else begin
        eligible     <= 1'b0;
        frame_done   <= 1'b0;
        final_status <= OUT_OK;
        tx_count     <= '0;
        retry_time   <= '0;
      end
    end
  end

endmodule

// ----- design/csma_retry_backoff_table_top.sv -----
// top level of the csma retry backoff table
// One command is taken at a clock edge with start high and busy low. It reads its
// destination entry from a small RAM with registered read, works out the retry in
// the calculate state (the backoff multiply is registered there) and writes the entry
// back in the finish state; the result is registered onto the outputs with done high
// as the finish state ends, and start is taken again while done is high, so a new
// command is accepted only once the last one is through. The receiver cannot stall:
// done lasts one cycle and the result must be taken then. There is no clearing pass
// after reset; the active flags are cleared at once. Configuration writes through
// cfg_we are taken at any edge, but belong only in cycles with busy and done low.
module csma_retry_backoff_table_top
  import crbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic [4:0]            dest_index,
  input  logic [2:0]            outcome,
  input  logic [TIME_W-1:0]     now,
  input  logic [7:0]            random_value,
  input  logic [7:0]            frame_max_transmissions,
  input  logic [TIME_W-1:0]     postpone_ticks,
  output logic                  done,
  output logic                  eligible,
  output logic                  frame_done,
  output logic [2:0]            final_status,
  output logic [CNT_W-1:0]      tx_count,
  output logic [TIME_W-1:0]     retry_time
);

  ctrl_cmd_t cmd;

  crbt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  crbt_datapath u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .mode                   (mode),
    .dest_index             (dest_index),
    .outcome                (outcome),
    .now                    (now),
    .random_value           (random_value),
    .frame_max_transmissions(frame_max_transmissions),
    .postpone_ticks         (postpone_ticks),
    .done                   (done),
    .eligible               (eligible),
    .frame_done             (frame_done),
    .final_status           (final_status),
    .tx_count               (tx_count),
    .retry_time             (retry_time)
  );

  // every accepted command yields exactly one result strobe
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe missing after transfer");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is in flight");

endmodule

// ----- tb/sv/crbt_checker.sv -----
`timescale 1ns / 100ps
// response checker with its own retry table predictor for the csma retry backoff table
module crbt_checker
  import crbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            mode,
  input  logic [4:0]            dest_index,
  input  logic [2:0]            outcome,
  input  logic [TIME_W-1:0]     now,
  input  logic [7:0]            random_value,
  input  logic [7:0]            frame_max_transmissions,
  input  logic [TIME_W-1:0]     postpone_ticks,
  input  logic                  done,
  input  logic                  eligible,
  input  logic                  frame_done,
  input  logic [2:0]            final_status,
  input  logic [CNT_W-1:0]      tx_count,
  input  logic [TIME_W-1:0]     retry_time,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic              elig;
    logic              fin;
    logic [2:0]        status;
    logic [CNT_W-1:0]  txc;
    logic [TIME_W-1:0] next;
  } table_resp_t;

  logic [3:0]        min_be;
  logic [3:0]        max_be;
  logic [CNT_W-1:0]  max_csma;
  logic [CNT_W-1:0]  dflt_max_tx;
  logic [15:0]       period;

  logic              slot_active [NUM_ENTRIES];
  logic [TIME_W-1:0] slot_next   [NUM_ENTRIES];
  logic [CNT_W-1:0]  slot_tx     [NUM_ENTRIES];
  logic [CNT_W-1:0]  slot_col    [NUM_ENTRIES];

  table_resp_t exp_resp_q[$];
  int          errs = 0;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // window grows with collisions plus transmissions, capped at max_be
  function automatic logic [TIME_W-1:0] retry_at(input int e, input logic [TIME_W-1:0] t,
                                                 input logic [7:0] rnd);
    int unsigned       be;
    logic [TIME_W-1:0] periods;
    be = 32'(slot_col[e]) + 32'(slot_tx[e]) + 32'(min_be);
    be = (be >= 1) ? be - 1 : 0;
    if (be > max_be) be = max_be;
    periods = 32'(rnd) & ((32'd1 << be) - 32'd1);
    return t + 32'(period) * periods;
  endfunction

  task automatic table_access(input logic [1:0] m, input logic [4:0] d, input logic [2:0] o,
                              input logic [TIME_W-1:0] t, input logic [7:0] rnd,
                              input logic [7:0] fmax, input logic [TIME_W-1:0] ticks,
                              output table_resp_t r);
    int                e;
    logic [CNT_W-1:0]  limit;
    logic [TIME_W-1:0] diff;
    r = '0;
    if (d > NUM_NEIGHBORS || m > MODE_CHECK) return;
    e = int'(d);
    if (!slot_active[e]) begin
      slot_active[e] = 1'b1;
      slot_next[e]   = t;
      slot_tx[e]     = '0;
      slot_col[e]    = '0;
    end
    case (m)
      MODE_CHECK: begin
        // wrap-safe: eligible unless now lies behind next
        diff   = t - slot_next[e];
        r.elig = ~diff[TIME_W-1];
      end
      MODE_POSTPONE: slot_next[e] = t + ticks;
      default: begin
        case (o)
          OUT_ERR: slot_next[e] = t + 32'(period);
          OUT_COLLISION: begin
            slot_col[e] = count_up(slot_col[e]);
            if (slot_col[e] <= max_csma) begin
              slot_next[e] = retry_at(e, t, rnd);
            end else begin
              r.fin    = 1'b1;
              r.status = OUT_COLLISION;
            end
          end
          OUT_NOACK: begin
            limit      = (fmax != 8'd0) ? fmax : dflt_max_tx;
            slot_tx[e] = count_up(slot_tx[e]);
            if (slot_tx[e] < limit) begin
              slot_next[e] = retry_at(e, t, rnd);
            end else begin
              r.fin    = 1'b1;
              r.status = OUT_NOACK;
            end
          end
          OUT_OK: begin
            slot_tx[e] = count_up(slot_tx[e]);
            r.fin      = 1'b1;
            r.status   = OUT_OK;
          end
          // fatal and the unknown codes above it
          default: begin
            r.fin    = 1'b1;
            r.status = OUT_FATAL;
          end
        endcase
        if (r.fin) slot_active[e] = 1'b0;
      end
    endcase
    r.txc  = slot_tx[e];
    r.next = slot_next[e];
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    table_resp_t got;
    table_resp_t want;
    table_resp_t pred;
    if (rst) begin
      min_be      = 4'd3;
      max_be      = 4'd5;
      max_csma    = 8'd4;
      dflt_max_tx = 8'd4;
      period      = 16'd1;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        slot_active[k] = 1'b0;
      end
      exp_resp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_BE:         min_be      = cfg_data[3:0];
          REG_MAX_BE:         max_be      = cfg_data[3:0];
          REG_MAX_CSMA:       max_csma    = cfg_data[7:0];
          REG_DEFAULT_MAX_TX: dflt_max_tx = cfg_data[7:0];
          REG_RETRY_PERIOD:   period      = cfg_data[15:0];
          default: ;
        endcase
      end
      // result transfer is checked before a command taken at the same edge
      if (done) begin
        got = '{eligible, frame_done, final_status, tx_count, retry_time};
        if (exp_resp_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result transfer, expected none, actual %0h", $time, got);
        end else begin
          want = exp_resp_q.pop_front();
          check_field("eligible", 32'(want.elig), 32'(got.elig));
          check_field("frame_done", 32'(want.fin), 32'(got.fin));
          check_field("final_status", 32'(want.status), 32'(got.status));
          check_field("tx_count", 32'(want.txc), 32'(got.txc));
          check_field("retry_time", want.next, got.next);
        end
      end
      if (start && !busy) begin
        table_access(mode, dest_index, outcome, now, random_value,
                     frame_max_transmissions, postpone_ticks, pred);
        exp_resp_q.push_back(pred);
      end
    end
    fail_count  <= errs;
    outstanding <= exp_resp_q.size();
  end

endmodule

// ----- tb/sv/tb_csma_retry_backoff_table_top.sv -----
`timescale 1ns / 100ps
// testbench top for the csma retry backoff table: clock, reset, command stimulus and verdict
module tb_csma_retry_backoff_table_top;
  import crbt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            mode = '0;
  logic [4:0]            dest_index = '0;
  logic [2:0]            outcome = '0;
  logic [TIME_W-1:0]     now = '0;
  logic [7:0]            random_value = '0;
  logic [7:0]            frame_max_transmissions = '0;
  logic [TIME_W-1:0]     postpone_ticks = '0;
  logic                  done;
  logic                  eligible;
  logic                  frame_done;
  logic [2:0]            final_status;
  logic [CNT_W-1:0]      tx_count;
  logic [TIME_W-1:0]     retry_time;

  int                    fail_count;
  int                    outstanding;
  int                    cycle_cnt = 0;
  bit                    idle_en = 1'b1;
  int                    idle_pct = 25;
  logic [TIME_W-1:0]     tick = 32'hFFFF_F000;

  always #10 clk = ~clk;

  csma_retry_backoff_table_top dut (
    .clk                     (clk),
    .rst                     (rst),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .start                   (start),
    .busy                    (busy),
    .mode                    (mode),
    .dest_index              (dest_index),
    .outcome                 (outcome),
    .now                     (now),
    .random_value            (random_value),
    .frame_max_transmissions (frame_max_transmissions),
    .postpone_ticks          (postpone_ticks),
    .done                    (done),
    .eligible                (eligible),
    .frame_done              (frame_done),
    .final_status            (final_status),
    .tx_count                (tx_count),
    .retry_time              (retry_time)
  );

  crbt_checker u_resp_chk (
    .clk                     (clk),
    .rst                     (rst),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .start                   (start),
    .busy                    (busy),
    .mode                    (mode),
    .dest_index              (dest_index),
    .outcome                 (outcome),
    .now                     (now),
    .random_value            (random_value),
    .frame_max_transmissions (frame_max_transmissions),
    .postpone_ticks          (postpone_ticks),
    .done                    (done),
    .eligible                (eligible),
    .frame_done              (frame_done),
    .final_status            (final_status),
    .tx_count                (tx_count),
    .retry_time              (retry_time),
    .fail_count              (fail_count),
    .outstanding             (outstanding)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one command transfer, with an optional idle burst in front
  task automatic issue(input logic [1:0] m, input logic [4:0] d, input logic [2:0] o,
                       input logic [TIME_W-1:0] t, input logic [7:0] r, input logic [7:0] f,
                       input logic [TIME_W-1:0] p);
    if (idle_en && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    mode                    <= m;
    dest_index              <= d;
    outcome                 <= o;
    now                     <= t;
    random_value            <= r;
    frame_max_transmissions <= f;
    postpone_ticks          <= p;
    start                   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop issuing and wait for every pending result plus a short tail
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] mn, input logic [3:0] mx, input logic [7:0] cs,
                            input logic [7:0] dm, input logic [15:0] per);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_BE;
    cfg_data  <= 16'(mn);
    @(posedge clk);
    cfg_index <= REG_MAX_BE;
    cfg_data  <= 16'(mx);
    @(posedge clk);
    cfg_index <= REG_MAX_CSMA;
    cfg_data  <= 16'(cs);
    @(posedge clk);
    cfg_index <= REG_DEFAULT_MAX_TX;
    cfg_data  <= 16'(dm);
    @(posedge clk);
    cfg_index <= REG_RETRY_PERIOD;
    cfg_data  <= per;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly frame traffic on a few hot entries so counters build up
  task automatic random_cmd(input int hot);
    int                pick;
    logic [1:0]        m;
    logic [4:0]        d;
    logic [2:0]        o;
    logic [7:0]        f;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] p;
    tick = tick + $urandom_range(0, 300);
    t = ($urandom_range(0, 19) == 0) ? $urandom : tick;
    pick = $urandom_range(0, 99);
    if (pick < 65) d = 5'(hot + $urandom_range(0, 2));
    else if (pick < 96) d = 5'($urandom_range(0, NUM_NEIGHBORS));
    else d = 5'($urandom_range(NUM_ENTRIES, 31));
    pick = $urandom_range(0, 99);
    if (pick < 55) m = MODE_REPORT;
    else if (pick < 70) m = MODE_POSTPONE;
    else if (pick < 97) m = MODE_CHECK;
    else m = MODE_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 30) o = OUT_NOACK;
    else if (pick < 55) o = OUT_COLLISION;
    else if (pick < 70) o = OUT_ERR;
    else if (pick < 88) o = OUT_OK;
    else if (pick < 94) o = OUT_FATAL;
    else o = 3'($urandom_range(OUT_FATAL + 1, 7));
    pick = $urandom_range(0, 99);
    if (pick < 25) f = 8'd0;
    else if (pick < 65) f = 8'($urandom_range(1, 6));
    else f = 8'($urandom);
    p = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600);
    issue(m, d, o, t, 8'($urandom), f, p);
  endtask

  task automatic random_phase(input int n);
    int hot;
    hot = $urandom_range(0, NUM_NEIGHBORS - 2);
    for (int i = 0; i < n; i++) begin
      // every 40 commands, pick at random a stretch with or without idle bursts
      if (i % 40 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      random_cmd(hot);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset configuration, directed corners
    issue(MODE_CHECK, 5'd0, OUT_OK, 32'd0, 8'd0, 8'd0, 32'd0);
    issue(MODE_POSTPONE, 5'd0, OUT_OK, 32'd0, 8'd0, 8'd0, 32'd100);
    issue(MODE_CHECK, 5'd0, OUT_OK, 32'd99, 8'd0, 8'd0, 32'd0);
    issue(MODE_CHECK, 5'd0, OUT_OK, 32'd100, 8'd0, 8'd0, 32'd0);
    issue(MODE_REPORT, 5'd1, OUT_ERR, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    repeat (5) issue(MODE_REPORT, 5'd2, OUT_COLLISION, 32'd1000, 8'hFF, 8'd0, 32'd0);
    repeat (4) issue(MODE_REPORT, 5'd3, OUT_NOACK, 32'd2000, 8'hAA, 8'd0, 32'd0);
    issue(MODE_REPORT, 5'd4, OUT_NOACK, 32'd3000, 8'hFF, 8'hFF, 32'd0);
    issue(MODE_REPORT, 5'd4, OUT_OK, 32'd3001, 8'd0, 8'hFF, 32'd0);
    issue(MODE_REPORT, 5'd5, OUT_FATAL, 32'd4000, 8'd0, 8'd0, 32'd0);
    issue(MODE_REPORT, 5'd6, 3'd7, 32'd4001, 8'd0, 8'd0, 32'd0);
    issue(MODE_REPORT, 5'(NUM_NEIGHBORS), OUT_OK, 32'd5000, 8'd0, 8'd0, 32'd0);
    issue(MODE_REPORT, 5'(NUM_ENTRIES), OUT_OK, 32'd5001, 8'd0, 8'd0, 32'd0);
    issue(MODE_CHECK, 5'd31, OUT_OK, 32'hFFFF_FFFF, 8'd0, 8'd0, 32'd0);
    issue(MODE_UNUSED, 5'd1, OUT_ERR, 32'd6000, 8'd0, 8'd0, 32'd5);
    // sign boundary of the eligibility difference
    issue(MODE_POSTPONE, 5'd7, OUT_OK, 32'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
    issue(MODE_CHECK, 5'd7, OUT_OK, 32'h7FFF_FFFE, 8'd0, 8'd0, 32'd0);
    issue(MODE_CHECK, 5'd7, OUT_OK, 32'h7FFF_FFFF, 8'd0, 8'd0, 32'd0);
    drain();

    // widest window, longest period, collision counter driven into saturation
    set_config(4'd0, 4'd8, 8'd255, 8'd1, 16'hFFFF);
    random_phase(200);
    for (int i = 0; i < 280; i++) begin
      tick = tick + 50;
      issue(MODE_REPORT, 5'd9, OUT_COLLISION, tick, 8'($urandom), 8'd0, 32'd0);
      if (i % 16 == 0) issue(MODE_CHECK, 5'd9, 3'($urandom), $urandom, 8'd0, 8'd0, 32'd0);
    end
    drain();

    set_config(4'd8, 4'd0, 8'd0, 8'd255, 16'd1);
    random_phase(250);
    drain();

    set_config(4'd3, 4'd5, 8'd4, 8'd4, 16'd100);
    random_phase(100);
    drain();

    // zero transmission limit and zero backoff period
    set_config(4'd2, 4'd6, 8'd2, 8'd0, 16'd0);
    issue(MODE_REPORT, 5'd8, OUT_NOACK, 32'd7000, 8'hFF, 8'd0, 32'd0);
    issue(MODE_REPORT, 5'd9, OUT_ERR, 32'd7001, 8'hFF, 8'd0, 32'd0);
    issue(MODE_REPORT, 5'd10, OUT_COLLISION, 32'd7002, 8'hFF, 8'd0, 32'd0);
    random_phase(200);
    drain();

    repeat (3) begin
      set_config(4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)),
                 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 255)),
                 8'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 255)),
                 16'($urandom_range(1, 65535)));
      random_phase(120);
      drain();
    end

    // back-to-back commands to close out the run
    set_config(4'd1, 4'd3, 8'd6, 8'd3, 16'd7);
    idle_en = 1'b0;
    random_phase(200);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/crbt_pkg.sv
design/crbt_ram.sv
design/crbt_ctrl.sv
design/crbt_datapath.sv
design/csma_retry_backoff_table_top.sv
tb/sv/crbt_checker.sv
tb/sv/tb_csma_retry_backoff_table_top.sv
